FILE: hdl/calendar_clock_counter_defines.svh
// Assertion macros shared by the calendar clock counter checker.
// Included by ccc_checker.sv; has no other dependencies.
`ifndef CALENDAR_CLOCK_COUNTER_DEFINES_SVH
`define CALENDAR_CLOCK_COUNTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CCC_ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("calendar clock counter check failed");

// The consequent must hold in the cycle after the antecedent.
`define CCC_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("calendar clock counter check failed");

`endif

FILE: hdl/ccc_pkg.sv
// Types, constants and calendar helper functions for the calendar clock counter.
// No dependencies; every other file of the block but the checker and its header uses it.
package ccc_pkg;

  typedef struct packed {
    logic [7:0] century;
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } caltime_t;

  typedef struct packed {
    logic     action;
    caltime_t load;
  } item_t;

  typedef struct packed {
    caltime_t next;
    logic     rejected;
  } step_t;

  typedef struct packed {
    caltime_t    now;
    logic [14:0] full_year;
    logic        alarm_reached;
    logic        load_rejected;
  } result_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ALARM_CENTURY = 3'd0,
    REG_ALARM_YEAR    = 3'd1,
    REG_ALARM_MONTH   = 3'd2,
    REG_ALARM_DAY     = 3'd3,
    REG_ALARM_HOUR    = 3'd4,
    REG_ALARM_MINUTE  = 3'd5,
    REG_ALARM_SECOND  = 3'd6
  } cfg_reg_t;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  localparam logic [7:0] CENTURY_MAX = 8'd255;
  localparam logic [6:0] YEAR_MAX    = 7'd99;
  localparam logic [3:0] MONTH_MAX   = 4'd11;
  localparam logic [4:0] DAY_MAX     = 5'd31;
  localparam logic [4:0] HOUR_MAX    = 5'd23;
  localparam logic [5:0] MINUTE_MAX  = 6'd59;
  localparam logic [5:0] SECOND_MAX  = 6'd59;

  localparam logic [3:0] MONTH_JAN = 4'd0;
  localparam logic [3:0] MONTH_FEB = 4'd1;
  localparam logic [3:0] MONTH_APR = 4'd3;
  localparam logic [3:0] MONTH_JUN = 4'd5;
  localparam logic [3:0] MONTH_SEP = 4'd8;
  localparam logic [3:0] MONTH_NOV = 4'd10;

  localparam caltime_t TIME_RESET = '{century: 8'd21, year: 7'd15, month: MONTH_JAN,
                                      day: 5'd1, hour: 5'd0, minute: 6'd0,
                                      second: 6'd0};
  localparam caltime_t TIME_MAX   = '{century: CENTURY_MAX, year: YEAR_MAX,
                                      month: MONTH_MAX, day: DAY_MAX, hour: HOUR_MAX,
                                      minute: MINUTE_MAX, second: SECOND_MAX};
  localparam caltime_t ALARM_RESET = '{century: 8'd255, year: 7'd0, month: MONTH_JAN,
                                       day: 5'd1, hour: 5'd0, minute: 6'd0,
                                       second: 6'd0};

  // Full year is year + 100 * (century - 1). With the year below 100 the year is
  // the full year modulo 100, and 100 is a multiple of 4, so the leap rule needs
  // no division: a year other than zero is leap when it is a multiple of 4, and
  // year zero is leap when century - 1 is a multiple of 4.
  function automatic logic is_leap(logic [7:0] century, logic [6:0] year);
    logic leap;
    if (year != 7'd0) begin
      leap = (year[1:0] == 2'b00);
    end else begin
      leap = (century[1:0] == 2'b01);
    end
    return leap;
  endfunction

  function automatic logic [4:0] days_in_month(logic [3:0] month, logic leap);
    logic [4:0] days;
    case (month)
      MONTH_FEB: days = leap ? 5'd29 : 5'd28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: days = 5'd30;
      default: days = 5'd31;
    endcase
    return days;
  endfunction

  function automatic logic [14:0] full_year_of(logic [7:0] century, logic [6:0] year);
    logic [7:0]  cm1;
    logic [14:0] hundreds;
    cm1      = century - 8'd1;
    hundreds = 15'(cm1) * 15'd100;
    return hundreds + 15'(year);
  endfunction

endpackage

FILE: hdl/ccc_ifs.sv
// Handshake channels of the calendar clock counter: input, result and register write.
// Depends on ccc_pkg for the register port widths.
interface ccc_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] new_century;
  logic [6:0] new_year;
  logic [3:0] new_month;
  logic [4:0] new_day;
  logic [4:0] new_hour;
  logic [5:0] new_minute;
  logic [5:0] new_second;

  modport source (output valid, action, new_century, new_year, new_month, new_day,
                  new_hour, new_minute, new_second, input ready);
  modport sink (input valid, action, new_century, new_year, new_month, new_day,
                new_hour, new_minute, new_second, output ready);
endinterface

interface ccc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  century;
  logic [6:0]  year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [14:0] full_year;
  logic        alarm_reached;
  logic        load_rejected;

  modport source (output valid, century, year, month, day, hour, minute, second,
                  full_year, alarm_reached, load_rejected, input ready);
  modport sink (input valid, century, year, month, day, hour, minute, second,
                full_year, alarm_reached, load_rejected, output ready);
endinterface

interface ccc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ccc_pkg::CFG_INDEX_W-1:0] index;
  logic [ccc_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/ccc_alarm_regs.sv
// Alarm time register file written through the configuration channel.
// Depends on ccc_pkg and ccc_ifs.
module ccc_alarm_regs (
  input  logic              clk,
  input  logic              rst,
  ccc_cfg_if.sink           cfg,
  output ccc_pkg::caltime_t alarm
);

  // Writes are always taken; an index beyond the list is dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm <= ccc_pkg::ALARM_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (ccc_pkg::cfg_reg_t'(cfg.index))
        ccc_pkg::REG_ALARM_CENTURY: alarm.century <= cfg.data;
        ccc_pkg::REG_ALARM_YEAR:    alarm.year    <= cfg.data[6:0];
        ccc_pkg::REG_ALARM_MONTH:   alarm.month   <= cfg.data[3:0];
        ccc_pkg::REG_ALARM_DAY:     alarm.day     <= cfg.data[4:0];
        ccc_pkg::REG_ALARM_HOUR:    alarm.hour    <= cfg.data[4:0];
        ccc_pkg::REG_ALARM_MINUTE:  alarm.minute  <= cfg.data[5:0];
        ccc_pkg::REG_ALARM_SECOND:  alarm.second  <= cfg.data[5:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/ccc_step.sv
// Next date-time for one request: one-second advance with carries, or a checked load.
// Depends on ccc_pkg.
module ccc_step (
  input  ccc_pkg::caltime_t cur,
  input  ccc_pkg::item_t    item,
  output ccc_pkg::step_t    res
);

  logic [4:0]        dim_cur;
  logic [4:0]        dim_new;
  logic              range_ok;
  logic              load_ok;
  ccc_pkg::caltime_t adv;

  always_comb begin
    dim_cur = ccc_pkg::days_in_month(cur.month, ccc_pkg::is_leap(cur.century, cur.year));
    dim_new = ccc_pkg::days_in_month(item.load.month,
                                     ccc_pkg::is_leap(item.load.century, item.load.year));

    range_ok = (item.load.century != 8'd0) &&
               (item.load.year <= ccc_pkg::YEAR_MAX) &&
               (item.load.month <= ccc_pkg::MONTH_MAX) &&
               (item.load.day != 5'd0) &&
               (item.load.hour <= ccc_pkg::HOUR_MAX) &&
               (item.load.minute <= ccc_pkg::MINUTE_MAX) &&
               (item.load.second <= ccc_pkg::SECOND_MAX);
    load_ok = range_ok && (item.load.day <= dim_new);

    // The held time is always consistent, so each unit rolls over exactly at its
    // limit. At the last second of century 255 the time stays put.
    adv = cur;
    if (cur != ccc_pkg::TIME_MAX) begin
      if (cur.second != ccc_pkg::SECOND_MAX) begin
        adv.second = cur.second + 6'd1;
      end else begin
        adv.second = 6'd0;
        if (cur.minute != ccc_pkg::MINUTE_MAX) begin
          adv.minute = cur.minute + 6'd1;
        end else begin
          adv.minute = 6'd0;
          if (cur.hour != ccc_pkg::HOUR_MAX) begin
            adv.hour = cur.hour + 5'd1;
          end else begin
            adv.hour = 5'd0;
            if (cur.day < dim_cur) begin
              adv.day = cur.day + 5'd1;
            end else begin
              adv.day = 5'd1;
              if (cur.month != ccc_pkg::MONTH_MAX) begin
                adv.month = cur.month + 4'd1;
              end else begin
                adv.month = ccc_pkg::MONTH_JAN;
                if (cur.year != ccc_pkg::YEAR_MAX) begin
                  adv.year = cur.year + 7'd1;
                end else begin
                  adv.year    = 7'd0;
                  adv.century = cur.century + 8'd1;
                end
              end
            end
          end
        end
      end
    end

    res.rejected = 1'b0;
    res.next     = adv;
    if (item.action == ccc_pkg::ACT_LOAD) begin
      res.next = cur;
      if (load_ok) begin
        res.next = item.load;
      end else begin
        res.rejected = 1'b1;
      end
    end
  end

endmodule

FILE: hdl/calendar_clock_counter.sv
// Calendar clock counter, top level.
// Depends on ccc_pkg, ccc_ifs, ccc_alarm_regs and ccc_step.
//
// Usage:
// - req carries one request per handshake: action 0 advances the time by one
//   second, action 1 loads new_century .. new_second if the date-time is valid.
// - rsp returns exactly one result per request: the time after it, the full
//   year, the alarm flag (time at or after the alarm) and the load reject flag.
// - cfg writes the alarm registers, index 0 century through 6 second; it is
//   always ready and a write to index 7 is dropped. Write only while idle.
// - An accepted request goes into the input register, then through the calendar
//   step and alarm compare into the result register.
// - Throughput is one request per cycle while the receiver does not stall; the time
//   register feeds the next request directly, so back-to-back requests see each other's updates.
// - When the receiver stalls, the result register holds and the input register
//   keeps taking requests until it is also full; req.ready then drops.
// - Synchronous reset sets the time to century 21, year 15, January 1 00:00:00,
//   the alarm to century 255 and empties both registers.
module calendar_clock_counter (
  input logic      clk,
  input logic      rst,
  ccc_in_if.sink   req,
  ccc_out_if.source rsp,
  ccc_cfg_if.sink  cfg
);

  ccc_pkg::caltime_t alarm;
  ccc_pkg::caltime_t cur;
  ccc_pkg::item_t    in_item;
  logic              in_vld;
  logic              out_vld;
  ccc_pkg::result_t  result;
  ccc_pkg::step_t    step;
  logic              fire;

  ccc_alarm_regs u_alarm_regs (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .alarm (alarm)
  );

  ccc_step u_step (
    .cur  (cur),
    .item (in_item),
    .res  (step)
  );

  assign fire      = in_vld && (!out_vld || rsp.ready);
  assign req.ready = !in_vld || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld  <= 1'b0;
      out_vld <= 1'b0;
      cur     <= ccc_pkg::TIME_RESET;
    end else begin
      if (req.valid && req.ready) begin
        in_vld <= 1'b1;
      end else if (fire) begin
        in_vld <= 1'b0;
      end
      if (fire) begin
        out_vld <= 1'b1;
        cur     <= step.next;
      end else if (rsp.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_item.action       <= req.action;
      in_item.load.century <= req.new_century;
      in_item.load.year    <= req.new_year;
      in_item.load.month   <= req.new_month;
      in_item.load.day     <= req.new_day;
      in_item.load.hour    <= req.new_hour;
      in_item.load.minute  <= req.new_minute;
      in_item.load.second  <= req.new_second;
    end
    if (fire) begin
      result.now           <= step.next;
      result.full_year     <= ccc_pkg::full_year_of(step.next.century, step.next.year);
      // Field widths match, so the packed compare is the field-by-field one.
      result.alarm_reached <= (step.next >= alarm);
      result.load_rejected <= step.rejected;
    end
  end

  assign rsp.valid         = out_vld;
  assign rsp.century       = result.now.century;
  assign rsp.year          = result.now.year;
  assign rsp.month         = result.now.month;
  assign rsp.day           = result.now.day;
  assign rsp.hour          = result.now.hour;
  assign rsp.minute        = result.now.minute;
  assign rsp.second        = result.now.second;
  assign rsp.full_year     = result.full_year;
  assign rsp.alarm_reached = result.alarm_reached;
  assign rsp.load_rejected = result.load_rejected;

endmodule

FILE: hdl/ccc_checker.sv
// Port-level checks for the calendar clock counter, bound to the top level.
// Depends on calendar_clock_counter_defines.svh and calendar_clock_counter.
`include "calendar_clock_counter_defines.svh"

module ccc_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [7:0]  rsp_century,
  input logic [6:0]  rsp_year,
  input logic [3:0]  rsp_month,
  input logic [4:0]  rsp_day,
  input logic [4:0]  rsp_hour,
  input logic [5:0]  rsp_minute,
  input logic [5:0]  rsp_second,
  input logic [14:0] rsp_full_year,
  input logic        rsp_alarm_reached,
  input logic        rsp_load_rejected
);

  // A stalled result keeps its contents.
  `CCC_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_century, rsp_year, rsp_month, rsp_day, rsp_hour, rsp_minute, rsp_second, rsp_full_year, rsp_alarm_reached, rsp_load_rejected}))

  // A result is waiting once an accepted request could have passed the input and result registers.
  `CCC_ASSERT_IMPLY(a_req_to_rsp, clk, rst, req_valid && req_ready, ##2 rsp_valid)

  // Requests are only held off while the result side is stalled.
  `CCC_ASSERT_IMPLY(a_backpressure, clk, rst, !req_ready, rsp_valid && !rsp_ready)

  // A delivered time always has every field within its range.
  `CCC_ASSERT_IMPLY(a_time_valid, clk, rst, rsp_valid, rsp_century != 8'd0 && rsp_year <= 7'd99 && rsp_month <= 4'd11 && rsp_day != 5'd0 && rsp_hour <= 5'd23 && rsp_minute <= 6'd59 && rsp_second <= 6'd59)

endmodule

bind calendar_clock_counter ccc_checker u_ccc_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_century       (rsp.century),
  .rsp_year          (rsp.year),
  .rsp_month         (rsp.month),
  .rsp_day           (rsp.day),
  .rsp_hour          (rsp.hour),
  .rsp_minute        (rsp.minute),
  .rsp_second        (rsp.second),
  .rsp_full_year     (rsp.full_year),
  .rsp_alarm_reached (rsp.alarm_reached),
  .rsp_load_rejected (rsp.load_rejected)
);

FILE: test/calendar_clock_counter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the calendar clock counter: directed and random requests,
// checked against an in-bench calendar predictor. Depends on ccc_pkg, ccc_ifs and the RTL.
module calendar_clock_counter_tb;

  localparam int LIMIT_CYCLES     = 400000;
  localparam int RANDOM_PER_PHASE = 370;
  localparam logic [ccc_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  logic clk;
  logic rst;

  ccc_in_if  req_if ();
  ccc_out_if rsp_if ();
  ccc_cfg_if cfg_if ();

  calendar_clock_counter DUT (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if),
    .cfg(cfg_if)
  );

  ccc_pkg::item_t    pending_items[$];
  ccc_pkg::result_t  expected_results[$];
  ccc_pkg::caltime_t clock_now;
  ccc_pkg::caltime_t alarm_now;
  ccc_pkg::result_t  seen_result;
  int                send_idle_pct  = 0;
  int                recv_stall_pct = 0;
  bit                hold_for_drain = 1'b0;
  int                sent_count     = 0;
  int                result_count   = 0;
  int                mismatch_count = 0;
  int                cycle_count    = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned year_number(logic [7:0] c, logic [6:0] y);
    return int'(y) + 100 * (int'(c) - 1);
  endfunction

  function automatic bit leap_year(int unsigned fy);
    return ((fy % 4 == 0) && (fy % 100 != 0)) || (fy % 400 == 0);
  endfunction

  function automatic int unsigned month_days(logic [7:0] c, logic [6:0] y, logic [3:0] m);
    int unsigned len;
    case (m)
      ccc_pkg::MONTH_FEB: len = leap_year(year_number(c, y)) ? 29 : 28;
      ccc_pkg::MONTH_APR, ccc_pkg::MONTH_JUN, ccc_pkg::MONTH_SEP,
      ccc_pkg::MONTH_NOV: len = 30;
      default: len = 31;
    endcase
    return len;
  endfunction

  function automatic ccc_pkg::caltime_t next_second(ccc_pkg::caltime_t t);
    logic carry;
    carry = 1'b1;
    // The century stops at its top: the last second of time stays put.
    if (t == ccc_pkg::TIME_MAX) return t;
    if (t.second < ccc_pkg::SECOND_MAX) begin
      t.second = t.second + 6'd1;
      carry = 1'b0;
    end else begin
      t.second = 6'd0;
    end
    if (carry) begin
      if (t.minute < ccc_pkg::MINUTE_MAX) begin
        t.minute = t.minute + 6'd1;
        carry = 1'b0;
      end else begin
        t.minute = 6'd0;
      end
    end
    if (carry) begin
      if (t.hour < ccc_pkg::HOUR_MAX) begin
        t.hour = t.hour + 5'd1;
        carry = 1'b0;
      end else begin
        t.hour = 5'd0;
      end
    end
    if (carry) begin
      if (t.day < month_days(t.century, t.year, t.month)) begin
        t.day = t.day + 5'd1;
        carry = 1'b0;
      end else begin
        t.day = 5'd1;
      end
    end
    if (carry) begin
      if (t.month < ccc_pkg::MONTH_MAX) begin
        t.month = t.month + 4'd1;
        carry = 1'b0;
      end else begin
        t.month = ccc_pkg::MONTH_JAN;
      end
    end
    if (carry) begin
      if (t.year < ccc_pkg::YEAR_MAX) begin
        t.year = t.year + 7'd1;
      end else begin
        t.year = 7'd0;
        t.century = t.century + 8'd1;
      end
    end
    return t;
  endfunction

  function automatic ccc_pkg::result_t apply_request(ccc_pkg::item_t it);
    ccc_pkg::result_t  r;
    logic              rejected;
    ccc_pkg::caltime_t ld;
    ld = it.load;
    rejected = 1'b0;
    if (it.action == ccc_pkg::ACT_LOAD) begin
      if (ld.century == 8'd0 || ld.year > ccc_pkg::YEAR_MAX ||
          ld.month > ccc_pkg::MONTH_MAX || ld.day == 5'd0 ||
          ld.hour > ccc_pkg::HOUR_MAX || ld.minute > ccc_pkg::MINUTE_MAX ||
          ld.second > ccc_pkg::SECOND_MAX) begin
        rejected = 1'b1;
      end else if (ld.day > month_days(ld.century, ld.year, ld.month)) begin
        rejected = 1'b1;
      end
      if (!rejected) clock_now = ld;
    end else begin
      clock_now = next_second(clock_now);
    end
    r.now           = clock_now;
    r.full_year     = 15'(year_number(clock_now.century, clock_now.year));
    // Packed field order is century first, so one unsigned compare is field by field.
    r.alarm_reached = (clock_now >= alarm_now);
    r.load_rejected = rejected;
    return r;
  endfunction

  // ---------------------------------------------------------------- request makers

  function automatic ccc_pkg::caltime_t random_caltime();
    ccc_pkg::caltime_t t;
    t.century = 8'($urandom);
    t.year    = 7'($urandom);
    t.month   = 4'($urandom);
    t.day     = 5'($urandom);
    t.hour    = 5'($urandom);
    t.minute  = 6'($urandom);
    t.second  = 6'($urandom);
    return t;
  endfunction

  function automatic ccc_pkg::item_t make_tick();
    ccc_pkg::item_t it;
    it.action = ccc_pkg::ACT_TICK;
    it.load   = random_caltime();
    return it;
  endfunction

  function automatic ccc_pkg::item_t make_load(int c, int y, int m, int d, int h, int mi,
                                               int s);
    ccc_pkg::item_t it;
    it.action       = ccc_pkg::ACT_LOAD;
    it.load.century = 8'(c);
    it.load.year    = 7'(y);
    it.load.month   = 4'(m);
    it.load.day     = 5'(d);
    it.load.hour    = 5'(h);
    it.load.minute  = 6'(mi);
    it.load.second  = 6'(s);
    return it;
  endfunction

  function automatic ccc_pkg::item_t random_valid_load();
    int c, y, m;
    c = $urandom_range(1, 255);
    y = $urandom_range(0, 99);
    m = $urandom_range(0, 11);
    return make_load(c, y, m, $urandom_range(1, month_days(8'(c), 7'(y), 4'(m))),
                     $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
  endfunction

  // A valid time a few seconds short of a minute, hour, day, month or year boundary.
  function automatic ccc_pkg::item_t near_rollover_load();
    int c, y, m, len, d, pick;
    pick = $urandom_range(0, 9);
    c = (pick == 0) ? 1 : (pick == 1) ? 255 : $urandom_range(1, 255);
    pick = $urandom_range(0, 9);
    y = (pick == 0) ? 0 : (pick == 1) ? 99 : $urandom_range(0, 99);
    pick = $urandom_range(0, 9);
    m = (pick < 2) ? 11 : (pick < 4) ? 1 : $urandom_range(0, 11);
    len = month_days(8'(c), 7'(y), 4'(m));
    pick = $urandom_range(0, 3);
    d = (pick < 2) ? len : (pick == 2) ? len - 1 : $urandom_range(1, len);
    return make_load(c, y, m, d,
                     ($urandom_range(0, 9) < 7) ? 23 : $urandom_range(0, 23),
                     ($urandom_range(0, 9) < 7) ? 59 : $urandom_range(0, 59),
                     $urandom_range(45, 59));
  endfunction

  task automatic fill_random(input int count);
    int             made;
    int             run;
    int             pick;
    ccc_pkg::item_t it;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        pending_items.push_back(near_rollover_load());
        run = $urandom_range(1, 25);
        repeat (run) pending_items.push_back(make_tick());
        made += run + 1;
      end else if (pick < 72) begin
        pending_items.push_back(random_valid_load());
        made += 1;
      end else if (pick < 90) begin
        it.action = ccc_pkg::ACT_LOAD;
        it.load   = random_caltime();
        pending_items.push_back(it);
        made += 1;
      end else begin
        pending_items.push_back(make_tick());
        made += 1;
      end
    end
  endtask

  // ---------------------------------------------------------------- register writes

  task automatic write_alarm_reg(input logic [ccc_pkg::CFG_INDEX_W-1:0] idx,
                                 input logic [ccc_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_alarm(input logic [7:0] c, input logic [7:0] y, input logic [7:0] m,
                           input logic [7:0] d, input logic [7:0] h, input logic [7:0] mi,
                           input logic [7:0] s);
    write_alarm_reg(ccc_pkg::REG_ALARM_CENTURY, c);
    write_alarm_reg(ccc_pkg::REG_ALARM_YEAR, y);
    write_alarm_reg(ccc_pkg::REG_ALARM_MONTH, m);
    write_alarm_reg(ccc_pkg::REG_ALARM_DAY, d);
    write_alarm_reg(ccc_pkg::REG_ALARM_HOUR, h);
    write_alarm_reg(ccc_pkg::REG_ALARM_MINUTE, mi);
    write_alarm_reg(ccc_pkg::REG_ALARM_SECOND, s);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      alarm_now = ccc_pkg::ALARM_RESET;
    end else if (cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.index)
        ccc_pkg::REG_ALARM_CENTURY: alarm_now.century = cfg_if.data;
        ccc_pkg::REG_ALARM_YEAR:    alarm_now.year    = cfg_if.data[6:0];
        ccc_pkg::REG_ALARM_MONTH:   alarm_now.month   = cfg_if.data[3:0];
        ccc_pkg::REG_ALARM_DAY:     alarm_now.day     = cfg_if.data[4:0];
        ccc_pkg::REG_ALARM_HOUR:    alarm_now.hour    = cfg_if.data[4:0];
        ccc_pkg::REG_ALARM_MINUTE:  alarm_now.minute  = cfg_if.data[5:0];
        ccc_pkg::REG_ALARM_SECOND:  alarm_now.second  = cfg_if.data[5:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (rst) begin
      clock_now = ccc_pkg::TIME_RESET;
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_results.push_back(apply_request(
          '{action: req_if.action,
            load: '{century: req_if.new_century, year: req_if.new_year,
                    month: req_if.new_month, day: req_if.new_day, hour: req_if.new_hour,
                    minute: req_if.new_minute, second: req_if.new_second}}));
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_items.size() != 0 && !hold_for_drain &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          req_if.valid       <= 1'b1;
          req_if.action      <= pending_items[0].action;
          req_if.new_century <= pending_items[0].load.century;
          req_if.new_year    <= pending_items[0].load.year;
          req_if.new_month   <= pending_items[0].load.month;
          req_if.new_day     <= pending_items[0].load.day;
          req_if.new_hour    <= pending_items[0].load.hour;
          req_if.new_minute  <= pending_items[0].load.minute;
          req_if.new_second  <= pending_items[0].load.second;
          void'(pending_items.pop_front());
          sent_count <= sent_count + 1;
          // Now and then stop sending until every outstanding request has been answered.
          if (sent_count % 397 == 200) hold_for_drain <= 1'b1;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
      if (hold_for_drain && !req_if.valid && expected_results.size() == 0) begin
        hold_for_drain <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic report_mismatch(input string what, input longint got_v,
                                 input longint want_v);
    mismatch_count++;
    $display("result %0d: %s is %0d, expected %0d", result_count, what, got_v, want_v);
  endtask

  task automatic check_result(input ccc_pkg::result_t got, input ccc_pkg::result_t want);
    if (got.now.century !== want.now.century)
      report_mismatch("century", got.now.century, want.now.century);
    if (got.now.year !== want.now.year)
      report_mismatch("year", got.now.year, want.now.year);
    if (got.now.month !== want.now.month)
      report_mismatch("month", got.now.month, want.now.month);
    if (got.now.day !== want.now.day)
      report_mismatch("day", got.now.day, want.now.day);
    if (got.now.hour !== want.now.hour)
      report_mismatch("hour", got.now.hour, want.now.hour);
    if (got.now.minute !== want.now.minute)
      report_mismatch("minute", got.now.minute, want.now.minute);
    if (got.now.second !== want.now.second)
      report_mismatch("second", got.now.second, want.now.second);
    if (got.full_year !== want.full_year)
      report_mismatch("full_year", got.full_year, want.full_year);
    if (got.alarm_reached !== want.alarm_reached)
      report_mismatch("alarm_reached", got.alarm_reached, want.alarm_reached);
    if (got.load_rejected !== want.load_rejected)
      report_mismatch("load_rejected", got.load_rejected, want.load_rejected);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (rsp_if.valid && rsp_if.ready) begin
        seen_result.now.century  = rsp_if.century;
        seen_result.now.year     = rsp_if.year;
        seen_result.now.month    = rsp_if.month;
        seen_result.now.day      = rsp_if.day;
        seen_result.now.hour     = rsp_if.hour;
        seen_result.now.minute   = rsp_if.minute;
        seen_result.now.second   = rsp_if.second;
        seen_result.full_year    = rsp_if.full_year;
        seen_result.alarm_reached = rsp_if.alarm_reached;
        seen_result.load_rejected = rsp_if.load_rejected;
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request outstanding, century",
                          seen_result.now.century, 0);
        end else begin
          check_result(seen_result, expected_results.pop_front());
        end
        result_count <= result_count + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("** calendar_clock_counter: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  task automatic wait_idle();
    while (pending_items.size() != 0 || req_if.valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  initial begin
    rst                = 1'b1;
    req_if.valid       = 1'b0;
    req_if.action      = ccc_pkg::ACT_TICK;
    req_if.new_century = '0;
    req_if.new_year    = '0;
    req_if.new_month   = '0;
    req_if.new_day     = '0;
    req_if.new_hour    = '0;
    req_if.new_minute  = '0;
    req_if.new_second  = '0;
    rsp_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = '0;
    cfg_if.data        = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed requests, against the alarm as it comes out of reset.
    pending_items.push_back(make_tick());
    pending_items.push_back(make_load(1, 0, ccc_pkg::MONTH_JAN, 1, 0, 0, 0));
    pending_items.push_back(make_load(255, 99, 11, 31, 23, 59, 59));
    pending_items.push_back(make_tick());
    pending_items.push_back(make_tick());
    pending_items.push_back(make_load(255, 98, 11, 31, 23, 59, 59));
    pending_items.push_back(make_tick());
    pending_items.push_back(make_load(254, 99, 11, 31, 23, 59, 59));
    pending_items.push_back(make_tick());
    pending_items.push_back(make_load(21, 0, ccc_pkg::MONTH_FEB, 29, 23, 59, 59));
    pending_items.push_back(make_tick());
    pending_items.push_back(make_load(20, 0, ccc_pkg::MONTH_FEB, 29, 12, 0, 0));
    pending_items.push_back(make_load(21, 24, ccc_pkg::MONTH_FEB, 28, 23, 59, 59));
    pending_items.push_back(make_tick());
    pending_items.push_back(make_load(21, 23, ccc_pkg::MONTH_FEB, 29, 0, 0, 0));
    pending_items.push_back(make_load(21, 23, ccc_pkg::MONTH_FEB, 28, 23, 59, 59));
    pending_items.push_back(make_tick());
    pending_items.push_back(make_load(0, 15, ccc_pkg::MONTH_JAN, 1, 0, 0, 0));
    pending_items.push_back(make_load(21, 100, ccc_pkg::MONTH_JAN, 1, 0, 0, 0));
    pending_items.push_back(make_load(21, 15, 12, 1, 0, 0, 0));
    pending_items.push_back(make_load(21, 15, ccc_pkg::MONTH_JAN, 0, 0, 0, 0));
    pending_items.push_back(make_load(21, 15, ccc_pkg::MONTH_APR, 31, 0, 0, 0));
    pending_items.push_back(make_load(21, 15, ccc_pkg::MONTH_JAN, 1, 24, 0, 0));
    pending_items.push_back(make_load(21, 15, ccc_pkg::MONTH_JAN, 1, 0, 60, 0));
    pending_items.push_back(make_load(21, 15, ccc_pkg::MONTH_JAN, 1, 0, 0, 60));
    pending_items.push_back(make_load(255, 127, 15, 31, 31, 63, 63));
    wait_idle();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
          set_alarm(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        end
        1: begin
          send_idle_pct = 87; recv_stall_pct = 0;
          set_alarm(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
          write_alarm_reg(REG_UNUSED, 8'($urandom));
        end
        2: begin
          send_idle_pct = 0;  recv_stall_pct = 87;
          set_alarm(8'($urandom_range(1, 255)), 8'($urandom_range(0, 99)),
                    8'($urandom_range(0, 11)), 8'($urandom_range(1, 31)),
                    8'($urandom_range(0, 23)), 8'($urandom_range(0, 59)),
                    8'($urandom_range(0, 59)));
        end
        3: begin
          send_idle_pct = 22; recv_stall_pct = 22;
          set_alarm(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom), 8'($urandom));
        end
        default: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
          set_alarm(8'd128, 8'd50, 8'd6, 8'd15, 8'd12, 8'd30, 8'd30);
        end
      endcase
      fill_random(RANDOM_PER_PHASE);
      wait_idle();
    end

    repeat (6) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** calendar_clock_counter: PASSED **");
    end else begin
      $display("** calendar_clock_counter: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/ccc_pkg.sv
hdl/ccc_ifs.sv
hdl/ccc_alarm_regs.sv
hdl/ccc_step.sv
hdl/calendar_clock_counter.sv
hdl/ccc_checker.sv
test/calendar_clock_counter_tb.sv
